// File: rtl/icdf_pkg.sv
// Shared types and constants for the inverse-CDF flow size sampler.
// Used by the divider, the sampler core and the checker under rtl; depends on nothing else.
`timescale 1ns / 1ps

package icdf_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int PROB_W     = 17;
  localparam int SIZE_W     = 32;
  localparam int IDX_W      = 6;
  localparam int ECNT_W     = 7;
  localparam int PROD_W     = PROB_W + SIZE_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SEL_BIT = 2;

  localparam logic [SIZE_W-1:0] RESET_DEFAULT_SIZE = 32'd1500;

  // Item actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Register selects, taken from paddr[CFG_SEL_BIT].
  localparam logic REG_ENTRY_COUNT  = 1'b0;
  localparam logic REG_DEFAULT_SIZE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic [PROB_W-1:0] entry_probability;
    logic [SIZE_W-1:0] entry_size;
    logic [PROB_W-1:0] uniform_sample;
  } in_beat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] flow_size;
    logic              matched;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [PROB_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/icdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module icdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/icdf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on icdf_pkg. The caller guarantees the quotient fits in SIZE_W bits.
`timescale 1ns / 1ps

module icdf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  icdf_pkg::div_req_t req,
  output icdf_pkg::div_rsp_t rsp
);

  import icdf_pkg::*;

  localparam int STEP_W = $clog2(SIZE_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [PROB_W-1:0] rem_r;
  logic [SIZE_W-1:0] shf_r;
  logic [PROB_W-1:0] den_r;

  logic [PROB_W:0]   trial;
  logic [PROB_W:0]   trial_sub;
  logic              ge;

  // The dividend's upper part is already below the divisor, so only the
  // low SIZE_W bits need a step each.
  always_comb begin
    trial     = {rem_r, shf_r[SIZE_W-1]};
    ge        = (trial >= {1'b0, den_r});
    trial_sub = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[PROD_W-1:SIZE_W];
      shf_r <= req.dividend[SIZE_W-1:0];
      den_r <= req.divisor;
      cnt_r <= STEP_W'(SIZE_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? trial_sub[PROB_W-1:0] : trial[PROB_W-1:0];
      shf_r <= {shf_r[SIZE_W-2:0], ge};
      cnt_r <= cnt_r - STEP_W'(1);
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0) && !req.start;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = shf_r;

endmodule

// File: rtl/inverse_cdf_flow_size_sampler_core.sv
// Inverse-CDF flow size sampler: table RAM, search sequencer and interpolation.
// Depends on icdf_pkg, icdf_ram and icdf_div.
`timescale 1ns / 1ps

// Usage:
// Input beats on in_valid/in_stall/in_data carry either a table load (action 0)
// or a sample (action 1). Every input beat produces exactly one output beat on
// out_valid/out_stall/out_data. Registers entry_count and default_size sit at
// byte addresses 0 and 4 of the APB port; the user must write them only while
// the block is idle, as the block does not enforce this. One item is worked on
// at a time; in_stall is high from acceptance until the result has moved into
// the output register. A load writes the table RAM in its accept cycle and then
// moves through S_DONE into the output register. A sample reads one entry per
// cycle from the table RAM. A match then passes through a multiply state, a
// divider setup state, 32 divider steps and a registered quotient return before
// S_DONE moves the result into the output register; a miss or a zero-width step
// goes from the search straight to S_DONE, and a sample with no entries from idle.
// The output register frees the core: a new item is accepted while a result
// waits under out_stall, and the next result waits in the core until taken.
// Reset (rst_n low, synchronous) empties the output, returns the sequencer to
// idle and restores the registers; the table is not cleared and an entry must
// be loaded before a sample reaches it.
module inverse_cdf_flow_size_sampler_core #(
  parameter int TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  icdf_pkg::in_beat_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output icdf_pkg::out_beat_t                    out_data,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [icdf_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [icdf_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [icdf_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  import icdf_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
  localparam int RAM_W = PROB_W + SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  // Configuration registers.
  logic [ECNT_W-1:0] entry_count_r;
  logic [SIZE_W-1:0] default_size_r;
  logic              cfg_wr;

  // Sequencer and datapath registers.
  state_t            state_r, state_nxt;
  logic [PROB_W-1:0] sample_r, sample_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [PROB_W-1:0] pprob_r, pprob_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt;
  logic [PROB_W-1:0] num_r, num_nxt;
  logic [PROB_W-1:0] den_r, den_nxt;
  logic [SIZE_W-1:0] diff_r, diff_nxt;
  logic              up_r, up_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;
  logic              res_matched_r, res_matched_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  // Table RAM port.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;

  logic [PROB_W-1:0] rd_prob;
  logic [SIZE_W-1:0] rd_size;
  logic              in_acc;
  logic              hit;
  logic              up_c;
  logic [CW-1:0]     count_eff;
  logic [CW-1:0]     idx_inc;
  logic [PROD_W-1:0] dividend;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r  <= '0;
      default_size_r <= RESET_DEFAULT_SIZE;
    end else if (cfg_wr) begin
      unique case (paddr[CFG_SEL_BIT])
        REG_ENTRY_COUNT:  entry_count_r  <= pwdata[ECNT_W-1:0];
        REG_DEFAULT_SIZE: default_size_r <= pwdata[SIZE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_SEL_BIT])
      REG_ENTRY_COUNT:  prdata = CFG_DATA_W'(entry_count_r);
      REG_DEFAULT_SIZE: prdata = default_size_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table RAM: probability in the upper bits, size in the lower bits.
  // ---------------------------------------------------------------------------
  icdf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  icdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign rd_prob   = ram_rdata[RAM_W-1 -: PROB_W];
  assign rd_size   = ram_rdata[SIZE_W-1:0];
  assign ram_waddr = AW'(in_data.entry_index);
  assign ram_wdata = {in_data.entry_probability, in_data.entry_size};

  always_comb begin
    count_eff = (CW'(entry_count_r) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : CW'(entry_count_r);
    idx_inc   = CW'(idx_r) + CW'(1);
    hit       = (sample_r <= rd_prob);
    up_c      = (rd_size >= psize_r);
    // Rounding the magnitude up on a falling step floors the signed quotient.
    dividend  = prod_r + (up_r ? PROD_W'(0) : (PROD_W'(den_r) - PROD_W'(1)));

    div_req.start    = (state_r == S_DIVGO);
    div_req.dividend = dividend;
    div_req.divisor  = den_r;

    state_nxt       = state_r;
    sample_nxt      = sample_r;
    idx_nxt         = idx_r;
    pprob_nxt       = pprob_r;
    psize_nxt       = psize_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    diff_nxt        = diff_r;
    up_nxt          = up_r;
    prod_nxt        = prod_r;
    res_size_nxt    = res_size_r;
    res_matched_nxt = res_matched_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == ACT_LOAD) begin
            ram_we          = (CW'(in_data.entry_index) < CW'(TABLE_DEPTH));
            res_size_nxt    = '0;
            res_matched_nxt = 1'b0;
            state_nxt       = S_DONE;
          end else begin
            sample_nxt = in_data.uniform_sample;
            idx_nxt    = '0;
            pprob_nxt  = '0;
            psize_nxt  = '0;
            ram_re     = 1'b1;
            if (count_eff == '0) begin
              res_size_nxt    = default_size_r;
              res_matched_nxt = 1'b0;
              state_nxt       = S_DONE;
            end else begin
              state_nxt = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          if (rd_prob == pprob_r) begin
            res_size_nxt    = psize_r;
            res_matched_nxt = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            num_nxt   = sample_r - pprob_r;
            den_nxt   = rd_prob - pprob_r;
            up_nxt    = up_c;
            diff_nxt  = up_c ? (rd_size - psize_r) : (psize_r - rd_size);
            state_nxt = S_MUL;
          end
        end else if (idx_inc >= count_eff) begin
          res_size_nxt    = default_size_r;
          res_matched_nxt = 1'b0;
          state_nxt       = S_DONE;
        end else begin
          pprob_nxt = rd_prob;
          psize_nxt = rd_size;
          idx_nxt   = CNT_W'(idx_inc);
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_inc);
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(num_r) * PROD_W'(diff_r);
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_size_nxt    = up_r ? (psize_r + div_rsp.quotient)
                                 : (psize_r - div_rsp.quotient);
          res_matched_nxt = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.flow_size = res_size_r;
          out_data_nxt.matched   = res_matched_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sample_r      <= sample_nxt;
    idx_r         <= idx_nxt;
    pprob_r       <= pprob_nxt;
    psize_r       <= psize_nxt;
    num_r         <= num_nxt;
    den_r         <= den_nxt;
    diff_r        <= diff_nxt;
    up_r          <= up_nxt;
    prod_r        <= prod_nxt;
    res_size_r    <= res_size_nxt;
    res_matched_r <= res_matched_nxt;
    out_data_r    <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/icdf_chk.sv
// Port-level checker for the sampler core, attached by the bind below.
// Depends on icdf_pkg and inverse_cdf_flow_size_sampler_core.
`timescale 1ns / 1ps

module icdf_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input icdf_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input icdf_pkg::out_beat_t out_data
);

  import icdf_pkg::*;

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

  // One item at a time: an accepted beat blocks the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again while an item is in work");

  // A load accepted while the output is empty yields a zero, unmatched beat once it has passed through S_DONE.
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.action == ACT_LOAD) && !out_valid)
    |=> ##1 (out_valid && (out_data.flow_size == '0) && !out_data.matched))
    else $error("load beat did not produce a zero result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed");

endmodule

bind inverse_cdf_flow_size_sampler_core icdf_chk u_chk (.*);

// File: dv/inverse_cdf_flow_size_sampler_core_tb.sv
// Self-checking bench for inverse_cdf_flow_size_sampler_core: table loads, size draws,
// register writes and read-back under random valid and stall gaps.
// Depends on icdf_pkg and the RTL of the sampler core.
`timescale 1ns / 1ps

module inverse_cdf_flow_size_sampler_core_tb;
  import icdf_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int TARGET_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'd65536;

  // Mirrors the sampler: table contents, registers and the beats still owed.
  class flow_size_ledger;
    bit [PROB_W-1:0] prob_tab[DEPTH];
    bit [SIZE_W-1:0] size_tab[DEPTH];
    bit              filled[DEPTH];
    bit [ECNT_W-1:0] entry_cnt;
    bit [SIZE_W-1:0] dflt_size;
    out_beat_t       owed[$];
    int              errors;
    int              loads;
    int              draws;
    int              hits;

    function new();
      entry_cnt = '0;
      dflt_size = RESET_DEFAULT_SIZE;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void set_reg(logic sel, bit [31:0] v);
      if (sel == REG_ENTRY_COUNT) entry_cnt = v[ECNT_W-1:0];
      else dflt_size = v;
    endfunction

    function bit [31:0] reg_value(logic sel);
      if (sel == REG_ENTRY_COUNT) return 32'(entry_cnt);
      return dflt_size;
    endfunction

    function int searched();
      return (entry_cnt > DEPTH) ? DEPTH : int'(entry_cnt);
    endfunction

    // Index of the first never-written entry a draw of u would read, or -1.
    function int first_blank_read(bit [PROB_W-1:0] u);
      int i;
      for (i = 0; i < searched(); i++) begin
        if (!filled[i]) return i;
        if (u <= prob_tab[i]) return -1;
      end
      return -1;
    endfunction

    function out_beat_t draw_size(in_beat_t it);
      out_beat_t       r;
      int              i;
      bit              found;
      bit [PROB_W-1:0] lo_p;
      bit [SIZE_W-1:0] lo_s;
      bit [SIZE_W-1:0] hi_s;
      bit [31:0]       span;
      bit [63:0]       num;
      bit [63:0]       den;
      bit [63:0]       q;
      r.flow_size = dflt_size;
      r.matched = 1'b0;
      found = 1'b0;
      for (i = 0; i < searched() && !found; i++) begin
        if (it.uniform_sample <= prob_tab[i]) begin
          found = 1'b1;
          lo_p = '0;
          lo_s = '0;
          if (i > 0) begin
            lo_p = prob_tab[i-1];
            lo_s = size_tab[i-1];
          end
          hi_s = size_tab[i];
          span = 32'(it.uniform_sample) - 32'(lo_p);
          num = 64'(span);
          span = 32'(prob_tab[i]) - 32'(lo_p);
          den = 64'(span);
          r.matched = 1'b1;
          if (den == 0) begin
            r.flow_size = lo_s;
          end else if (hi_s >= lo_s) begin
            q = (num * 64'(hi_s - lo_s)) / den;
            r.flow_size = lo_s + q[31:0];
          end else begin
            // A falling step is floored, so the magnitude rounds up.
            q = (num * 64'(lo_s - hi_s) + den - 1) / den;
            r.flow_size = lo_s - q[31:0];
          end
        end
      end
      return r;
    endfunction

    function void note_item(in_beat_t it);
      out_beat_t r;
      r = '0;
      if (it.action == ACT_LOAD) begin
        prob_tab[it.entry_index] = it.entry_probability;
        size_tab[it.entry_index] = it.entry_size;
        filled[it.entry_index] = 1'b1;
        loads++;
      end else begin
        r = draw_size(it);
        draws++;
        if (r.matched) hits++;
      end
      owed.insert(owed.size(), r);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (owed.size() == 0) begin
        flag($sformatf("result beat with nothing outstanding: size %0d matched %0d",
                       got.flow_size, got.matched));
        return;
      end
      want = owed.pop_front();
      if (got.flow_size !== want.flow_size)
        flag($sformatf("flow_size mismatch: expected %0d, got %0d",
                       want.flow_size, got.flow_size));
      if (got.matched !== want.matched)
        flag($sformatf("matched mismatch: expected %0d, got %0d", want.matched, got.matched));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  flow_size_ledger ledger;
  int  cycles = 0;
  int  items_sent = 0;
  int  settings = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  inverse_cdf_flow_size_sampler_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, ledger.owed.size());
      $display("inverse_cdf_flow_size_sampler_core verification failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 27);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_beat(out_data);
  end

  function automatic void addr_of(logic sel, output logic [CFG_ADDR_W-1:0] a);
    a = '0;
    a[CFG_SEL_BIT] = sel;
  endfunction

  // Leaves psel high; cfg_release ends a group of accesses.
  task automatic cfg_access(logic sel, bit wr, bit [31:0] v);
    logic [CFG_ADDR_W-1:0] a;
    addr_of(sel, a);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr) begin
      ledger.set_reg(sel, v);
    end else if (prdata !== ledger.reg_value(sel)) begin
      ledger.flag($sformatf("register %0d read back: expected %0h, got %0h",
                            sel, ledger.reg_value(sel), prdata));
    end
  endtask

  task automatic cfg_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_table_regs(bit [31:0] count, bit [31:0] dflt);
    cfg_access(REG_ENTRY_COUNT, 1'b1, count);
    cfg_access(REG_DEFAULT_SIZE, 1'b1, dflt);
    cfg_access(REG_ENTRY_COUNT, 1'b0, '0);
    cfg_access(REG_DEFAULT_SIZE, 1'b0, '0);
    cfg_release();
    settings++;
  endtask

  // Called just after the clock rises; returns once the core has accepted the beat.
  task automatic offer(in_beat_t it);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_item(it);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.owed.size() != 0) @(posedge clk);
  endtask

  function automatic in_beat_t load_beat(int idx, bit [PROB_W-1:0] p, bit [SIZE_W-1:0] sz);
    in_beat_t it;
    it.action = ACT_LOAD;
    it.entry_index = idx[IDX_W-1:0];
    it.entry_probability = p;
    it.entry_size = sz;
    it.uniform_sample = PROB_W'($urandom);
    return it;
  endfunction

  function automatic in_beat_t draw_beat(bit [PROB_W-1:0] u);
    in_beat_t it;
    it.action = ACT_SAMPLE;
    it.entry_index = IDX_W'($urandom);
    it.entry_probability = PROB_W'($urandom);
    it.entry_size = $urandom;
    it.uniform_sample = u;
    return it;
  endfunction

  // Draws that would touch a never-written entry turn into a load of that entry.
  task automatic offer_draw(bit [PROB_W-1:0] u);
    int blank;
    blank = ledger.first_blank_read(u);
    if (blank < 0) offer(draw_beat(u));
    else offer(load_beat(blank, PROB_W'($urandom_range(0, 65536)), $urandom));
  endtask

  function automatic bit [PROB_W-1:0] pick_u();
    int n;
    int k;
    bit [PROB_W:0] v;
    n = ledger.searched();
    case ($urandom_range(0, 7)) inside
      0: return '0;
      1: return PROB_ONE;
      [2:3]: begin
        if (n == 0) return PROB_W'($urandom_range(0, 65536));
        k = $urandom_range(0, n - 1);
        v = {1'b0, ledger.prob_tab[k]} + (PROB_W+1)'($urandom_range(0, 1));
        return (v > PROB_ONE) ? PROB_ONE : v[PROB_W-1:0];
      end
      default: return PROB_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Loads a nondecreasing CDF into entries 0..n-1.
  task automatic load_cdf(int n);
    bit [31:0] p;
    bit [63:0] sz;
    bit        wild_sizes;
    bit        full_top;
    int        i;
    p = 0;
    sz = 0;
    wild_sizes = ($urandom_range(0, 3) == 0);
    full_top = ($urandom_range(0, 3) != 0);
    for (i = 0; i < n; i++) begin
      p += $urandom_range(0, 131072 / n);
      if (p > 65536 || (full_top && i == n - 1)) p = 65536;
      sz += 64'($urandom_range(0, 32'hFFFFFFFF / n));
      if (sz > 64'hFFFFFFFF) sz = 64'hFFFFFFFF;
      offer(load_beat(i, p[PROB_W-1:0], wild_sizes ? $urandom : sz[31:0]));
    end
  endtask

  initial begin
    int phase;
    int mix;
    int j;
    bit [31:0] count;
    bit [31:0] dflt;
    ledger = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers after reset, then a draw from an empty search.
    cfg_access(REG_ENTRY_COUNT, 1'b0, '0);
    cfg_access(REG_DEFAULT_SIZE, 1'b0, '0);
    cfg_release();
    offer(draw_beat(PROB_ONE));
    // Zero-probability first entry, a nonmonotone entry, a falling step, full sizes.
    offer(load_beat(0, 17'd0, 32'd100));
    offer(load_beat(1, 17'd16384, 32'd2000));
    offer(load_beat(2, 17'd10000, 32'd800));
    offer(load_beat(3, 17'd40000, 32'd50));
    offer(load_beat(4, 17'd65535, 32'hFFFFFFFF));
    offer(load_beat(5, PROB_ONE, 32'hFFFFFFFF));
    offer(draw_beat(17'd30000));
    drain();
    set_table_regs(6, 32'hFFFFFFFF);
    offer(draw_beat(17'd0));
    offer(draw_beat(17'd1));
    offer(draw_beat(17'd16384));
    offer(draw_beat(17'd16385));
    offer(draw_beat(17'd40000));
    offer(draw_beat(17'd40001));
    offer(draw_beat(17'd65535));
    offer(draw_beat(PROB_ONE));
    drain();
    // The sender waits for every result before the table shrinks.
    set_table_regs(4, 32'h0);
    offer(draw_beat(17'd65535));
    offer(draw_beat(17'd50000));
    drain();

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0: count = 64;
        1: count = 127;
        2: count = 1;
        3: count = 0;
        default: begin
          case ($urandom_range(0, 9))
            0: count = 0;
            1: count = 64;
            2: count = $urandom_range(65, 127);
            default: count = $urandom_range(1, 10);
          endcase
        end
      endcase
      case (phase)
        0: dflt = 32'hFFFFFFFF;
        1: dflt = 32'h0;
        default: dflt = $urandom;
      endcase
      set_table_regs(count, dflt);
      calm <= (phase == 4);
      if (count > 0) load_cdf((count > DEPTH) ? DEPTH : int'(count));
      mix = $urandom_range(50, 110);
      for (j = 0; j < mix; j++) begin
        // The result side holds off here while beats keep coming.
        if (phase == 2 && j == 10) hold_req <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          offer(load_beat($urandom_range(0, DEPTH - 1),
                          PROB_W'($urandom_range(0, 65536)), $urandom));
        else
          offer_draw(pick_u());
      end
      drain();
      phase++;
    end

    repeat (150) @(posedge clk);
    if (ledger.owed.size() != 0)
      ledger.flag($sformatf("%0d expected beats never arrived", ledger.owed.size()));
    $display("Ran %0d beats: %0d table loads, %0d draws (%0d matched) over %0d register settings.",
             items_sent, ledger.loads, ledger.draws, ledger.hits, settings);
    $display("Mismatches: %0d", ledger.errors);
    if (ledger.errors == 0) begin
      $display("inverse_cdf_flow_size_sampler_core verification clean");
    end else begin
      $display("inverse_cdf_flow_size_sampler_core verification failed");
    end
    $finish;
  end

endmodule
